[src/rfrx_pkg.sv]
// Shared types, constants and codes for the serial frame receiver and health monitor.
package rfrx_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int POS_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0]  START_BYTE      = 8'h05;
    localparam logic [7:0]  END_BYTE        = 8'h04;
    localparam logic [7:0]  ADDR_BYTE_RESET = 8'h68;
    localparam logic [15:0] TACHO_MIN_RESET = 16'd50;

    localparam logic [1:0] REG_ADDR_BYTE = 2'd0;
    localparam logic [1:0] REG_TACHO_MIN = 2'd1;
    localparam logic [1:0] REG_FAN_EN    = 2'd2;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_PULSE = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]  address_byte;
        logic [15:0] tacho_min;
        logic        fan_en;
    } t_cfg;

    typedef struct packed {
        logic byte_ev;
        logic pulse_ev;
        logic tick_ev;
    } t_event;

    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   length;
        logic               overflow;
    } t_frame_status;

    typedef struct packed {
        logic        com_loss;
        logic        tacho_low;
        logic [15:0] fan_time;
        logic [15:0] period_count;
    } t_health_status;

endpackage

[src/rs485_frame_rx_and_health_monitor_core.sv]
// Serial frame receiver and health monitor: one item per cycle while results are taken.
// An accepted item updates framer, buffer and health state at the accepting edge; its
// result is valid in the next cycle from those registers and the buffer read port.
// Throughput is one item per cycle while the result side takes results; a stalled
// result holds the input side stalled. Synchronous active-low reset returns framer to
// idle, clears counters and flags, and restores register defaults; the buffer is not cleared.
module rs485_frame_rx_and_health_monitor_core import rfrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic [4:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_done,
    output logic [5:0]  o_frame_length,
    output logic        o_overflow,
    output logic        o_link_loss,
    output logic        o_tacho_low,
    output logic [15:0] o_fan_time,
    output logic [15:0] o_tacho_period_count,
    output logic [7:0]  o_read_data
);

    t_cfg           cfg;
    t_event         ev;
    t_frame_status  frame_st;
    t_health_status health_st;
    logic           accept;
    logic           rd_ev;
    logic           done;
    logic           wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic [7:0]     wr_data;
    logic [7:0]     ram_q;
    logic           r_out_valid, n_out_valid;
    logic           r_done;
    logic           r_rd_sel;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign ev.byte_ev  = accept && (i_operation == OP_BYTE);
    assign ev.pulse_ev = accept && (i_operation == OP_PULSE);
    assign ev.tick_ev  = accept && (i_operation == OP_TICK);
    assign rd_ev       = accept && (i_operation == OP_READ);

    rfrx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rfrx_framer u_framer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_ev      (ev.byte_ev),
        .i_byte         (i_rx_byte),
        .i_address_byte (cfg.address_byte),
        .o_done         (done),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_status       (frame_st)
    );

    rfrx_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_ev),
        .i_rd_addr (BUF_AW'(i_read_index)),
        .o_rd_data (ram_q)
    );

    rfrx_health u_health (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ev     (ev),
        .i_cfg    (cfg),
        .o_status (health_st)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_rd_sel    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_done   <= done;
                r_rd_sel <= rd_ev && (int'(i_read_index) < BUF_DEPTH);
            end
        end
    end

    // state only moves on accept, so the live state is the held result
    assign o_out_valid          = r_out_valid;
    assign o_frame_done         = r_done;
    assign o_frame_length       = 6'(frame_st.length);
    assign o_overflow           = frame_st.overflow;
    assign o_link_loss          = health_st.com_loss;
    assign o_tacho_low          = health_st.tacho_low;
    assign o_fan_time           = health_st.fan_time;
    assign o_tacho_period_count = health_st.period_count;
    assign o_read_data          = r_rd_sel ? ram_q : 8'd0;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_length_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(frame_st.length) <= BUF_DEPTH)
        else $error("write position beyond buffer depth");

    a_done_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (frame_st.phase == PH_IDLE))
        else $error("frame done reported while framer not idle");

    a_write_in_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (ev.byte_ev && frame_st.phase == PH_DATA))
        else $error("buffer write outside data phase");

endmodule

[src/rfrx_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module rfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/rfrx_regs.sv]
// APB configuration registers: address byte, tacho minimum, fan timer enable.
module rfrx_regs import rfrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_go;

    assign pready = 1'b1;
    assign wr_go  = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_go) begin
            unique case (paddr[3:2])
                REG_ADDR_BYTE: n_cfg.address_byte = pwdata[7:0];
                REG_TACHO_MIN: n_cfg.tacho_min    = pwdata[15:0];
                REG_FAN_EN:    n_cfg.fan_en       = pwdata[0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_byte <= ADDR_BYTE_RESET;
            r_cfg.tacho_min    <= TACHO_MIN_RESET;
            r_cfg.fan_en       <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ADDR_BYTE: prdata = {24'd0, r_cfg.address_byte};
            REG_TACHO_MIN: prdata = {16'd0, r_cfg.tacho_min};
            REG_FAN_EN:    prdata = {31'd0, r_cfg.fan_en};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[src/rfrx_framer.sv]
// Idle/address/data framer with buffer write position and overflow flag.
module rfrx_framer import rfrx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_ev,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_address_byte,
    output logic              o_done,
    output logic              o_wr_en,
    output logic [BUF_AW-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output t_frame_status     o_status
);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_ovf, n_ovf;
    logic             buf_full;

    assign buf_full = (r_pos >= POS_W'(BUF_DEPTH));

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_ovf   = r_ovf;
        if (i_byte_ev) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == START_BYTE) begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (i_byte == i_address_byte) begin
                        n_phase = PH_DATA;
                        n_pos   = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    if (i_byte == END_BYTE) begin
                        n_phase = PH_IDLE;
                    end else if (!buf_full) begin
                        n_pos = r_pos + 1'b1;
                    end else begin
                        // drop the byte, remember it for this frame
                        n_ovf = 1'b1;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        o_done    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = BUF_AW'(r_pos);
        o_wr_data = i_byte;
        if (i_byte_ev && r_phase == PH_DATA) begin
            o_done  = (i_byte == END_BYTE);
            o_wr_en = (i_byte != END_BYTE) && !buf_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
        end
    end

    assign o_status.phase    = r_phase;
    assign o_status.length   = r_pos;
    assign o_status.overflow = r_ovf;

endmodule

[src/rfrx_health.sv]
// Link activity, tacho rate and fan timer bookkeeping per period.
module rfrx_health import rfrx_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_event         i_ev,
    input  t_cfg           i_cfg,
    output t_health_status o_status
);

    logic        r_byte_seen, n_byte_seen;
    logic [15:0] r_pulse_cnt, n_pulse_cnt;
    logic [15:0] r_last_pulses, n_last_pulses;
    logic [15:0] r_fan, n_fan;
    logic        r_com_loss, n_com_loss;
    logic        r_tacho_low, n_tacho_low;

    always_comb begin
        n_byte_seen   = r_byte_seen;
        n_pulse_cnt   = r_pulse_cnt;
        n_last_pulses = r_last_pulses;
        n_fan         = r_fan;
        n_com_loss    = r_com_loss;
        n_tacho_low   = r_tacho_low;
        if (i_ev.byte_ev) begin
            n_byte_seen = 1'b1;
        end
        // saturate the pulse count
        if (i_ev.pulse_ev && r_pulse_cnt != 16'hFFFF) begin
            n_pulse_cnt = r_pulse_cnt + 16'd1;
        end
        if (i_ev.tick_ev) begin
            n_com_loss    = ~r_byte_seen;
            n_byte_seen   = 1'b0;
            n_fan         = i_cfg.fan_en ? r_fan + 16'd1 : r_fan;
            // judge the period before the one just closed
            n_tacho_low   = (r_last_pulses < i_cfg.tacho_min);
            n_last_pulses = r_pulse_cnt;
            n_pulse_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_seen   <= 1'b0;
            r_pulse_cnt   <= '0;
            r_last_pulses <= '0;
            r_fan         <= '0;
            r_com_loss    <= 1'b0;
            r_tacho_low   <= 1'b0;
        end else begin
            r_byte_seen   <= n_byte_seen;
            r_pulse_cnt   <= n_pulse_cnt;
            r_last_pulses <= n_last_pulses;
            r_fan         <= n_fan;
            r_com_loss    <= n_com_loss;
            r_tacho_low   <= n_tacho_low;
        end
    end

    assign o_status.com_loss     = r_com_loss;
    assign o_status.tacho_low    = r_tacho_low;
    assign o_status.fan_time     = r_fan;
    assign o_status.period_count = r_last_pulses;

endmodule
